// ===== rtl/bgc_pkg.sv =====
package bgc_pkg;

  localparam int KIND_W  = 2;
  localparam int COUNT_W = 11;
  localparam int END_W   = 10;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_EDGE  = 2'd1,
    KIND_EVAL  = 2'd2
  } kind_t;

  localparam logic [1:0] COLOR_ZERO = 2'd0;
  localparam logic [1:0] COLOR_ONE  = 2'd1;
  localparam logic [1:0] COLOR_NONE = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COUNT_W-1:0] vertex_count;
    logic [END_W-1:0]   end_a;
    logic [END_W-1:0]   end_b;
  } in_item_t;

  typedef struct packed {
    logic is_bipartite;
    logic overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HCLR,
    ST_EA_RD,
    ST_EA_WR,
    ST_EB_WR,
    ST_CCLR,
    ST_SCAN_RD,
    ST_SCAN_CK,
    ST_POP,
    ST_POP_WAIT,
    ST_HEAD_WAIT,
    ST_EDGE,
    ST_EDGE_WAIT,
    ST_COLOR_WAIT,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/bgc_out_reg.sv =====
module bgc_out_reg
  import bgc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load_valid,
  input  out_item_t load_data,
  output logic      load_ready,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result
);

  // take a new beat when empty or when the held one leaves this cycle
  assign load_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_ready) begin
      result_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      result <= load_data;
    end
  end

endmodule

// ===== rtl/bipartite_graph_check_unit.sv =====
// Bipartite check over a graph built from a stream of item beats.
// Input channel item/item_valid/item_ready carries one command per beat:
//   start (vertex count), add edge (end_a, end_b) or evaluate.
// Output channel result/result_valid/result_ready carries one beat per
//   evaluate: is_bipartite and the sticky overflow flag.
// One item is worked at a time; item_ready is high only while idle.
//   start:    empties the adjacency heads of the N vertices (N = vertex count).
//   edge:     two read-modify-writes of the head memory.
//   evaluate: clears the N colors, scans every vertex, roots a component at
//             each uncolored one and walks it, popping vertices and walking
//             their half-edges; a color clash cuts the walk short.
// The walk cost is set by the single read port of each memory: every step
// needs one registered read before its data is known.
// Reset empties the graph (zero vertices) and clears overflow; no memory
// sweep is needed after reset. A result waits in an output register while
// the receiver stalls, and new items are still taken meanwhile; a second
// evaluate holds in its final state until the register is free.
module bipartite_graph_check_unit
  import bgc_pkg::*;
#(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result
);

  localparam int VW   = $clog2(MAX_VERTICES);   // vertex index
  localparam int GW   = VW + 1;                 // vertex count
  localparam int HALF = 2 * MAX_EDGES;
  localparam int EIW  = $clog2(HALF);           // half-edge index
  localparam int SW   = $clog2(HALF + 1);       // half-edge slot incl. empty marker
  localparam int ETW  = $clog2(MAX_EDGES + 1);  // edge count

  localparam logic [SW-1:0] NO_EDGE = SW'(HALF);

  state_t st, st_next;

  logic [GW-1:0]  graph_size, graph_size_next;
  logic [ETW-1:0] edge_total, edge_total_next;
  logic           dropped, dropped_next;
  logic [GW-1:0]  idx, idx_next;
  logic [GW-1:0]  depth, depth_next;
  logic [VW-1:0]  va, va_next;
  logic [VW-1:0]  vb, vb_next;
  logic [VW-1:0]  v, v_next;
  logic           vc, vc_next;
  logic [SW-1:0]  e, e_next;
  logic [VW-1:0]  w, w_next;
  logic           bip, bip_next;

  // memories
  logic [SW-1:0] head_mem  [MAX_VERTICES];
  logic [VW-1:0] tgt_mem   [HALF];
  logic [SW-1:0] link_mem  [HALF];
  logic [1:0]    color_mem [MAX_VERTICES];
  logic [VW:0]   stack_mem [MAX_VERTICES];

  logic          head_re, head_we;
  logic [VW-1:0] head_raddr, head_waddr;
  logic [SW-1:0] head_wdata, head_rd;

  logic           edge_re, edge_we;
  logic [EIW-1:0] edge_raddr, edge_waddr;
  logic [VW-1:0]  edge_wtgt, tgt_rd;
  logic [SW-1:0]  edge_wlink, link_rd;

  logic          color_re, color_we;
  logic [VW-1:0] color_raddr, color_waddr;
  logic [1:0]    color_wdata, color_rd;

  logic          stack_re, stack_we;
  logic [VW-1:0] stack_raddr, stack_waddr;
  logic [VW:0]   stack_wdata, stack_rd;

  logic          load_valid, load_ready;
  out_item_t     load_data;

  logic          accept;
  logic [SW-1:0] slot_a, slot_b;
  logic          edge_bad;

  assign accept = item_valid && item_ready;
  assign slot_a = SW'({edge_total, 1'b0});
  assign slot_b = SW'({edge_total, 1'b1});
  assign edge_bad = (32'(item.end_a) >= 32'(graph_size)) ||
                    (32'(item.end_b) >= 32'(graph_size)) ||
                    (32'(edge_total) >= MAX_EDGES);

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (head_re) begin
      head_rd <= head_mem[head_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      tgt_mem[edge_waddr]  <= edge_wtgt;
      link_mem[edge_waddr] <= edge_wlink;
    end
    if (edge_re) begin
      tgt_rd  <= tgt_mem[edge_raddr];
      link_rd <= link_mem[edge_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (color_we) begin
      color_mem[color_waddr] <= color_wdata;
    end
    if (color_re) begin
      color_rd <= color_mem[color_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wdata;
    end
    if (stack_re) begin
      stack_rd <= stack_mem[stack_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= ST_IDLE;
      graph_size <= '0;
      edge_total <= '0;
      dropped    <= 1'b0;
      idx        <= '0;
      depth      <= '0;
    end else begin
      st         <= st_next;
      graph_size <= graph_size_next;
      edge_total <= edge_total_next;
      dropped    <= dropped_next;
      idx        <= idx_next;
      depth      <= depth_next;
    end
  end

  always_ff @(posedge clk) begin
    va  <= va_next;
    vb  <= vb_next;
    v   <= v_next;
    vc  <= vc_next;
    e   <= e_next;
    w   <= w_next;
    bip <= bip_next;
  end

  always_comb begin
    st_next         = st;
    graph_size_next = graph_size;
    edge_total_next = edge_total;
    dropped_next    = dropped;
    idx_next        = idx;
    depth_next      = depth;
    va_next         = va;
    vb_next         = vb;
    v_next          = v;
    vc_next         = vc;
    e_next          = e;
    w_next          = w;
    bip_next        = bip;

    item_ready  = 1'b0;
    head_re     = 1'b0;
    head_we     = 1'b0;
    head_raddr  = '0;
    head_waddr  = '0;
    head_wdata  = '0;
    edge_re     = 1'b0;
    edge_we     = 1'b0;
    edge_raddr  = '0;
    edge_waddr  = '0;
    edge_wtgt   = '0;
    edge_wlink  = '0;
    color_re    = 1'b0;
    color_we    = 1'b0;
    color_raddr = '0;
    color_waddr = '0;
    color_wdata = COLOR_NONE;
    stack_re    = 1'b0;
    stack_we    = 1'b0;
    stack_raddr = '0;
    stack_waddr = '0;
    stack_wdata = '0;
    load_valid  = 1'b0;

    case (st)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (accept) begin
          case (item.kind)
            KIND_START: begin
              dropped_next    = 1'b0;
              edge_total_next = '0;
              idx_next        = '0;
              if (32'(item.vertex_count) > MAX_VERTICES) begin
                graph_size_next = GW'(MAX_VERTICES);
                dropped_next    = 1'b1;
                st_next         = ST_HCLR;
              end else begin
                graph_size_next = GW'(item.vertex_count);
                if (item.vertex_count != '0) begin
                  st_next = ST_HCLR;
                end
              end
            end
            KIND_EDGE: begin
              if (edge_bad) begin
                dropped_next = 1'b1;
              end else begin
                va_next = VW'(item.end_a);
                vb_next = VW'(item.end_b);
                st_next = ST_EA_RD;
              end
            end
            KIND_EVAL: begin
              idx_next = '0;
              bip_next = 1'b1;
              if (graph_size == '0) begin
                st_next = ST_DONE;
              end else begin
                st_next = ST_CCLR;
              end
            end
            default: begin
              // unused kind: drop it
            end
          endcase
        end
      end

      // empty the list heads of the new graph
      ST_HCLR: begin
        head_we    = 1'b1;
        head_waddr = idx[VW-1:0];
        head_wdata = NO_EDGE;
        idx_next   = idx + GW'(1);
        if (idx + GW'(1) == graph_size) begin
          st_next = ST_IDLE;
        end
      end

      ST_EA_RD: begin
        head_re    = 1'b1;
        head_raddr = va;
        st_next    = ST_EA_WR;
      end

      // link the a-side half-edge, fetch the b-side head
      ST_EA_WR: begin
        edge_we    = 1'b1;
        edge_waddr = slot_a[EIW-1:0];
        edge_wtgt  = vb;
        edge_wlink = head_rd;
        head_we    = 1'b1;
        head_waddr = va;
        head_wdata = slot_a;
        head_re    = 1'b1;
        head_raddr = vb;
        st_next    = ST_EB_WR;
      end

      // forward the fresh a-side head on a self-loop
      ST_EB_WR: begin
        edge_we         = 1'b1;
        edge_waddr      = slot_b[EIW-1:0];
        edge_wtgt       = va;
        edge_wlink      = (va == vb) ? slot_a : head_rd;
        head_we         = 1'b1;
        head_waddr      = vb;
        head_wdata      = slot_b;
        edge_total_next = edge_total + ETW'(1);
        st_next         = ST_IDLE;
      end

      ST_CCLR: begin
        color_we    = 1'b1;
        color_waddr = idx[VW-1:0];
        color_wdata = COLOR_NONE;
        if (idx + GW'(1) == graph_size) begin
          idx_next = '0;
          st_next  = ST_SCAN_RD;
        end else begin
          idx_next = idx + GW'(1);
        end
      end

      ST_SCAN_RD: begin
        if (idx == graph_size) begin
          st_next = ST_DONE;
        end else begin
          color_re    = 1'b1;
          color_raddr = idx[VW-1:0];
          st_next     = ST_SCAN_CK;
        end
      end

      // root a new component at an uncolored vertex
      ST_SCAN_CK: begin
        if (color_rd != COLOR_NONE) begin
          idx_next = idx + GW'(1);
          st_next  = ST_SCAN_RD;
        end else begin
          color_we    = 1'b1;
          color_waddr = idx[VW-1:0];
          color_wdata = COLOR_ONE;
          v_next      = idx[VW-1:0];
          vc_next     = 1'b1;
          head_re     = 1'b1;
          head_raddr  = idx[VW-1:0];
          st_next     = ST_HEAD_WAIT;
        end
      end

      ST_POP: begin
        if (depth == '0) begin
          idx_next = idx + GW'(1);
          st_next  = ST_SCAN_RD;
        end else begin
          stack_re    = 1'b1;
          stack_raddr = VW'(depth - GW'(1));
          depth_next  = depth - GW'(1);
          st_next     = ST_POP_WAIT;
        end
      end

      ST_POP_WAIT: begin
        vc_next    = stack_rd[VW];
        v_next     = stack_rd[VW-1:0];
        head_re    = 1'b1;
        head_raddr = stack_rd[VW-1:0];
        st_next    = ST_HEAD_WAIT;
      end

      ST_HEAD_WAIT: begin
        e_next  = head_rd;
        st_next = ST_EDGE;
      end

      ST_EDGE: begin
        if (e == NO_EDGE) begin
          st_next = ST_POP;
        end else begin
          edge_re    = 1'b1;
          edge_raddr = e[EIW-1:0];
          st_next    = ST_EDGE_WAIT;
        end
      end

      ST_EDGE_WAIT: begin
        w_next      = tgt_rd;
        e_next      = link_rd;
        color_re    = 1'b1;
        color_raddr = tgt_rd;
        st_next     = ST_COLOR_WAIT;
      end

      // same color ends the walk and empties the stack; uncolored gets the
      // opposite and is pushed
      ST_COLOR_WAIT: begin
        if (color_rd == {1'b0, vc}) begin
          bip_next   = 1'b0;
          depth_next = '0;
          st_next    = ST_DONE;
        end else begin
          if (color_rd == COLOR_NONE) begin
            color_we    = 1'b1;
            color_waddr = w;
            color_wdata = vc ? COLOR_ZERO : COLOR_ONE;
            stack_we    = 1'b1;
            stack_waddr = depth[VW-1:0];
            stack_wdata = {~vc, w};
            depth_next  = depth + GW'(1);
          end
          st_next = ST_EDGE;
        end
      end

      ST_DONE: begin
        load_valid = 1'b1;
        if (load_ready) begin
          st_next = ST_IDLE;
        end
      end

      default: begin
        st_next = ST_IDLE;
      end
    endcase
  end

  assign load_data.is_bipartite = bip;
  assign load_data.overflow     = dropped;

  bgc_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (load_valid),
    .load_data    (load_data),
    .load_ready   (load_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

`ifndef SYNTH
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= graph_size)
    else $error("walk stack deeper than vertex count");

  a_edge_bound: assert property (@(posedge clk) disable iff (rst)
    32'(edge_total) <= MAX_EDGES)
    else $error("edge count beyond capacity");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(st == ST_DONE))
    else $error("result beat without a finished evaluate");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import bgc_pkg::*;

  localparam int N_VERT      = 1024;
  localparam int N_EDGE      = 4096;
  localparam int NO_LINK     = 2 * N_EDGE;
  localparam int ITEM_TARGET = 2000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // One entry of the stimulus queue: a beat to send, or a marker that holds
  // the sender until every expected verdict has arrived.
  typedef struct {
    bit       drain;
    in_item_t beat;
  } pending_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_ready;
  in_item_t  item = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_item_t result;

  pending_t  pending_q[$];
  out_item_t verdict_q[$];

  int total_items;
  int sent_items;
  int verdicts_seen;
  int non_bipartite_seen;
  int overflow_seen;
  int graphs_built;
  int mismatches;
  int tx_idle_pct;
  int rx_idle_pct;

  // Shadow graph, updated as each beat is accepted.
  int unsigned graph_size;
  int unsigned edge_total;
  bit          dropped;
  int          list_head[N_VERT];
  int          half_target[NO_LINK];
  int          half_link[NO_LINK];
  int          color[N_VERT];
  int          walk[N_VERT];

  bipartite_graph_check_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Depth-first two-coloring of the shadow graph; colors 0/1, 2 is uncolored.
  function automatic bit color_graph();
    int unsigned depth;
    int v;
    int e;
    int w;
    for (int s = 0; s < graph_size; s++) color[s] = 2;
    for (int s = 0; s < graph_size; s++) begin
      if (color[s] != 2) continue;
      color[s] = 1;
      walk[0] = s;
      depth = 1;
      while (depth > 0) begin
        depth--;
        v = walk[depth];
        for (e = list_head[v]; e < NO_LINK; e = half_link[e]) begin
          w = half_target[e];
          if (w >= graph_size) continue;
          if (color[w] == color[v]) return 1'b0;
          if (color[w] == 2) begin
            color[w] = color[v] ^ 1;
            if (depth < N_VERT) begin
              walk[depth] = w;
              depth++;
            end
          end
        end
      end
    end
    return 1'b1;
  endfunction

  // Apply one accepted beat to the shadow graph; queue a verdict on evaluate.
  task automatic apply_beat(input in_item_t b);
    out_item_t v;
    case (b.kind)
      KIND_START: begin
        dropped = 1'b0;
        edge_total = 0;
        for (int i = 0; i < N_VERT; i++) list_head[i] = NO_LINK;
        if (b.vertex_count > N_VERT) begin
          graph_size = N_VERT;
          dropped = 1'b1;
        end else begin
          graph_size = b.vertex_count;
        end
      end
      KIND_EDGE: begin
        if (b.end_a >= graph_size || b.end_b >= graph_size || edge_total >= N_EDGE) begin
          dropped = 1'b1;
        end else begin
          half_target[2*edge_total] = b.end_b;
          half_link[2*edge_total] = list_head[b.end_a];
          list_head[b.end_a] = 2*edge_total;
          half_target[2*edge_total+1] = b.end_a;
          half_link[2*edge_total+1] = list_head[b.end_b];
          list_head[b.end_b] = 2*edge_total + 1;
          edge_total++;
        end
      end
      KIND_EVAL: begin
        v.is_bipartite = color_graph();
        v.overflow = dropped;
        verdict_q.push_back(v);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic push_beat(input logic [1:0] kind, input int count, input int a, input int b);
    pending_t p;
    p.drain = 1'b0;
    p.beat.kind = kind;
    p.beat.vertex_count = count[COUNT_W-1:0];
    p.beat.end_a = a[END_W-1:0];
    p.beat.end_b = b[END_W-1:0];
    pending_q.push_back(p);
    if (kind == KIND_START) graphs_built++;
  endtask

  task automatic push_drain();
    pending_t p;
    p.drain = 1'b1;
    p.beat = '0;
    pending_q.push_back(p);
  endtask

  // Random graph: mostly edges across a random two-way split, some random
  // edges that may break bipartiteness, and some noise beats.
  task automatic push_random_graph(input int n, input int edges, input bit split_only);
    bit side[N_VERT];
    int a;
    int b;
    int lim;
    push_beat(KIND_START, n, $urandom_range(1023), $urandom_range(1023));
    lim = (n > N_VERT) ? N_VERT : n;
    for (int i = 0; i < lim; i++) side[i] = $urandom_range(1);
    for (int k = 0; k < edges; k++) begin
      if ($urandom_range(99) < 8) begin
        // noise: out-of-range endpoint or an unused kind
        if ($urandom_range(1))
          push_beat(KIND_EDGE, $urandom, $urandom_range(1023), $urandom_range(1023));
        else
          push_beat(KIND_UNUSED, $urandom, $urandom_range(1023), $urandom_range(1023));
      end else if (lim > 0) begin
        a = $urandom_range(lim - 1);
        b = $urandom_range(lim - 1);
        for (int t = 0; t < 8 && (split_only || $urandom_range(9) != 0) && side[a] == side[b];
             t++)
          b = $urandom_range(lim - 1);
        push_beat(KIND_EDGE, $urandom_range(2047), a, b);
      end
    end
    push_beat(KIND_EVAL, $urandom_range(2047), $urandom_range(1023), $urandom_range(1023));
    if ($urandom_range(9) == 0)
      push_beat(KIND_EVAL, 0, 0, 0);
  endtask

  // Driver: present one beat at a time; hold it until accepted.
  always @(posedge clk) begin
    bit holding;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        apply_beat(item);
        sent_items++;
      end
      holding = item_valid && !item_ready;
      if (!holding) begin
        // drop a drain marker once all verdicts are in
        if (pending_q.size() > 0 && pending_q[0].drain && verdict_q.size() == 0)
          void'(pending_q.pop_front());
        if (pending_q.size() > 0 && !pending_q[0].drain &&
            $urandom_range(99) >= tx_idle_pct) begin
          item <= pending_q[0].beat;
          item_valid <= 1'b1;
          void'(pending_q.pop_front());
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, check each verdict beat against the oldest.
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        verdicts_seen++;
        if (!result.is_bipartite) non_bipartite_seen++;
        if (result.overflow) overflow_seen++;
        if (verdict_q.size() == 0) begin
          report_mismatch("unexpected verdict, is_bipartite", result.is_bipartite, -1);
        end else begin
          want = verdict_q.pop_front();
          if (result.is_bipartite !== want.is_bipartite)
            report_mismatch("is_bipartite", result.is_bipartite, want.is_bipartite);
          if (result.overflow !== want.overflow)
            report_mismatch("overflow", result.overflow, want.overflow);
        end
      end
      result_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Idling phases follow progress through the stimulus.
  always @(posedge clk) begin
    if (sent_items < total_items / 3) begin
      tx_idle_pct <= 30;
      rx_idle_pct <= 64;
    end else if (sent_items < 2 * total_items / 3) begin
      tx_idle_pct <= 64;
      rx_idle_pct <= 30;
    end else begin
      tx_idle_pct <= 0;
      rx_idle_pct <= 0;
    end
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int n;
    // Directed: empty graphs, range drops, odd cycle, oversized count,
    // self-loop, top endpoints, unused kind.
    push_beat(KIND_EVAL, 0, 0, 0);
    push_beat(KIND_START, 0, 1023, 1023);
    push_beat(KIND_EVAL, 0, 0, 0);
    push_beat(KIND_START, 1, 0, 0);
    push_beat(KIND_EDGE, 0, 0, 1);
    push_beat(KIND_EVAL, 0, 0, 0);
    push_beat(KIND_START, 3, 0, 0);
    push_beat(KIND_EDGE, 0, 0, 1);
    push_beat(KIND_EDGE, 0, 1, 2);
    push_beat(KIND_EVAL, 0, 0, 0);
    push_beat(KIND_EDGE, 0, 2, 0);
    push_beat(KIND_EVAL, 0, 0, 0);
    push_drain();
    push_beat(KIND_START, 2047, 0, 0);
    push_beat(KIND_EDGE, 2047, 1023, 1022);
    push_beat(KIND_EDGE, 0, 0, 1023);
    push_beat(KIND_EVAL, 0, 0, 0);
    push_beat(KIND_EDGE, 0, 1023, 1023);
    push_beat(KIND_EVAL, 0, 0, 0);
    push_beat(KIND_UNUSED, 2047, 1023, 1023);
    push_beat(KIND_START, 1024, 0, 0);
    push_beat(KIND_EDGE, 0, 512, 511);
    push_beat(KIND_EVAL, 0, 0, 0);
    push_beat(KIND_START, 5, 0, 0);
    push_beat(KIND_EDGE, 0, 4, 5);
    push_beat(KIND_EVAL, 0, 0, 0);

    // Random graphs, mostly small; a few at full size or oversized.
    while (pending_q.size() < ITEM_TARGET) begin
      if ($urandom_range(19) == 0)
        n = $urandom_range(2047, 900);
      else
        n = $urandom_range(24);
      push_random_graph(n, $urandom_range(2 * n + 3) % 200, $urandom_range(99) < 55);
      if ($urandom_range(14) == 0) push_drain();
    end
    push_drain();
    for (int g = 0; g < 12; g++) push_random_graph($urandom_range(24), $urandom_range(30), 1'b0);
    total_items = pending_q.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() > 0 || item_valid || verdict_q.size() > 0) @(posedge clk);
    repeat (2000) @(posedge clk);

    $display("covered %0d beats over %0d graphs, small, full size and oversized",
             sent_items, graphs_built);
    $display("%0d verdicts checked: %0d not bipartite, %0d with overflow",
             verdicts_seen, non_bipartite_seen, overflow_seen);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== bipartite_graph_check_unit.f =====
rtl/bgc_pkg.sv
rtl/bgc_out_reg.sv
rtl/bipartite_graph_check_unit.sv
tb/tb_top.sv
